FILE: sv/fr2p_pkg.sv
// Package for the fisheye ray-to-pixel projector: request and result types,
// configuration register indexes, sequencer states, the arctangent table and helpers.
// No dependencies.
package fr2p_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int CORDIC_STEPS  = 30;
  localparam int CFG_IW        = 3;
  localparam int CFG_DW        = 28;

  localparam logic [CFG_IW-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_AFFINE_C   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_AFFINE_D   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_AFFINE_E   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_POLY_TERMS = 3'd5;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         coef_index;
    logic signed [47:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } fr2p_in_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               at_center;
  } fr2p_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_NINIT, S_NORM, S_CORD, S_DXI, S_DIVX,
    S_DYI, S_DIVY, S_HINIT, S_HSET, S_HMUL, S_XS, S_YS, S_U1, S_U2, S_V1,
    S_V2, S_FIN
  } fr2p_state_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021687;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      default: r = 32'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] a);
    return a[47] ? 48'(-a) : 48'(a);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v > 49'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -49'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -51'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: sv/fisheye_ray_to_pixel.sv
// Sequencing: a coefficient load is written when accepted; a projection runs through the
// shared 32x32 multiplier, square root, normalize, CORDIC and divide loops, and a zero
// planar norm goes from the square root straight to the finish state.
// Throughput: one projection at a time; the next request enters when the sequencer is idle.
// Reset: synchronous active-low rst_n zeroes control/config registers but C=65536, terms=1.
// The coefficient table has no reset and holds garbage until written.
module fisheye_ray_to_pixel #(
  parameter int MAX_TERMS = fr2p_pkg::MAX_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fr2p_pkg::fr2p_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fr2p_pkg::fr2p_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [fr2p_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [fr2p_pkg::CFG_DW-1:0]    cfg_wdata
);
  import fr2p_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [5:0] MAXT = 6'(MAX_TERMS);

  fr2p_state_t state_r, state_nxt;

  logic [27:0]        center_x_r, center_y_r;
  logic signed [17:0] affine_c_r, affine_d_r, affine_e_r;
  logic [4:0]         poly_terms_r;

  logic signed [47:0] coef_mem [MAX_TERMS];
  logic signed [47:0] coef_rd_r;
  logic [AW-1:0]      rd_addr;

  logic signed [31:0] px_r, py_r, pz_r;
  logic [4:0]         cnt_r;
  logic [2:0]         mcnt_r;
  logic               is_mul, mul_done;
  logic signed [47:0] mul_a, mul_b;
  logic [5:0]         mul_sh;
  logic [47:0]        ma_r, mb_r;
  logic               neg_r;
  logic [5:0]         sh_r;
  logic [63:0]        prod_r;
  logic [95:0]        acc_r;
  logic signed [47:0] mres_r;
  logic [31:0]        pa, pb;

  logic [63:0]        rem_r, res_r, bit_r;
  logic [31:0]        n_r;
  logic [39:0]        m_r;
  logic signed [43:0] cx_r, cy_r;
  logic signed [31:0] th_r;
  logic [32:0]        drem_r;
  logic [31:0]        dsh_r;
  logic signed [47:0] qx_r, qy_r, rho_r, xs_r, ys_r;
  logic signed [49:0] ua_r, va_r;
  logic               at_center_r;
  logic [AW-1:0]      k_r, k_init;
  logic               out_valid_r;
  fr2p_out_t          out_data_r;

  logic [5:0]         terms6;
  logic               fin_go;

  always_comb begin
    terms6 = (poly_terms_r == 5'd0) ? 6'd1 : 6'(poly_terms_r);
    if (terms6 > MAXT) terms6 = MAXT;
    k_init = AW'(terms6 - 6'd1);
  end

  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign mul_done = (mcnt_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid && in_data.mode == MODE_PROJECT) state_nxt = S_SQX;
      S_SQX:   if (mul_done) state_nxt = S_SQY;
      S_SQY:   if (mul_done) state_nxt = S_SQRT;
      S_SQRT:  if (cnt_r == 5'd31) state_nxt = S_NINIT;
      S_NINIT: state_nxt = (res_r == 64'd0) ? S_FIN : S_NORM;
      S_NORM:  if (m_r[39]) state_nxt = S_CORD;
      S_CORD:  if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_DXI;
      S_DXI:   state_nxt = S_DIVX;
      S_DIVX:  if (cnt_r == 5'd31) state_nxt = S_DYI;
      S_DYI:   state_nxt = S_DIVY;
      S_DIVY:  if (cnt_r == 5'd31) state_nxt = S_HINIT;
      S_HINIT: state_nxt = S_HSET;
      S_HSET:  state_nxt = (k_r == '0) ? S_XS : S_HMUL;
      S_HMUL:  if (mul_done && k_r == AW'(1)) state_nxt = S_XS;
      S_XS:    if (mul_done) state_nxt = S_YS;
      S_YS:    if (mul_done) state_nxt = S_U1;
      S_U1:    if (mul_done) state_nxt = S_U2;
      S_U2:    if (mul_done) state_nxt = S_V1;
      S_V1:    if (mul_done) state_nxt = S_V2;
      S_V2:    if (mul_done) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    is_mul   = 1'b0;
    mul_a    = 48'sd0;
    mul_b    = 48'sd0;
    mul_sh   = 6'd30;
    rd_addr  = k_r;
    case (state_r)
      S_SQX: begin is_mul = 1'b1; mul_a = 48'(px_r); mul_b = 48'(px_r); end
      S_SQY: begin is_mul = 1'b1; mul_a = 48'(py_r); mul_b = 48'(py_r); end
      S_HINIT: rd_addr = k_init;
      S_HMUL: begin
        is_mul = 1'b1; mul_a = rho_r; mul_b = 48'(th_r); rd_addr = k_r - AW'(1);
      end
      S_XS: begin is_mul = 1'b1; mul_a = qx_r; mul_b = rho_r; end
      S_YS: begin is_mul = 1'b1; mul_a = qy_r; mul_b = rho_r; end
      S_U1: begin is_mul = 1'b1; mul_a = xs_r; mul_b = 48'(affine_c_r); mul_sh = 6'd32; end
      S_U2: begin is_mul = 1'b1; mul_a = ys_r; mul_b = 48'(affine_d_r); mul_sh = 6'd32; end
      S_V1: begin is_mul = 1'b1; mul_a = xs_r; mul_b = 48'(affine_e_r); mul_sh = 6'd32; end
      S_V2: begin is_mul = 1'b1; mul_a = ys_r; mul_b = 48'sd1; mul_sh = 6'd16; end
      default: ;
    endcase
  end

  always_comb begin
    case (mcnt_r)
      3'd1:    begin pa = ma_r[31:0];          pb = mb_r[31:0];          end
      3'd2:    begin pa = ma_r[31:0];          pb = {16'd0, mb_r[47:32]}; end
      3'd3:    begin pa = {16'd0, ma_r[47:32]}; pb = mb_r[31:0];          end
      default: begin pa = {16'd0, ma_r[47:32]}; pb = {16'd0, mb_r[47:32]}; end
    endcase
  end

  logic [95:0] rnd_sum, rnd_shf, rnd_lim;
  logic [47:0] rnd_q;
  always_comb begin
    rnd_sum = acc_r + (96'd1 << (sh_r - 6'd1));
    rnd_shf = rnd_sum >> sh_r;
    rnd_lim = neg_r ? (96'd1 << 47) : ((96'd1 << 47) - 96'd1);
    rnd_q   = (rnd_shf > rnd_lim) ? rnd_lim[47:0] : rnd_shf[47:0];
  end

  logic [63:0]        sq_try;
  logic [32:0]        dt;
  logic               dge;
  logic [32:0]        drem_nxt;
  logic [31:0]        dq;
  logic [31:0]        pabs;
  logic [61:0]        dnum;
  logic [31:0]        zabs;
  always_comb begin
    sq_try   = res_r + bit_r;
    dt       = {drem_r[31:0], dsh_r[31]};
    dge      = (dt >= {1'b0, n_r});
    drem_nxt = dge ? dt - {1'b0, n_r} : dt;
    dq       = {dsh_r[30:0], dge};
    pabs     = (state_r == S_DXI) ? (px_r[31] ? 32'(-px_r) : 32'(px_r))
                                  : (py_r[31] ? 32'(-py_r) : 32'(py_r));
    dnum     = {pabs, 30'd0} + 62'(n_r >> 1);
    zabs     = pz_r[31] ? 32'(-pz_r) : 32'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cnt_r        <= 5'd0;
      mcnt_r       <= 3'd0;
      center_x_r   <= 28'd0;
      center_y_r   <= 28'd0;
      affine_c_r   <= 18'sd65536;
      affine_d_r   <= 18'sd0;
      affine_e_r   <= 18'sd0;
      poly_terms_r <= 5'd1;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) cnt_r <= 5'd0;
      else if (state_r == S_SQRT || state_r == S_CORD || state_r == S_DIVX ||
               state_r == S_DIVY) cnt_r <= cnt_r + 5'd1;
      mcnt_r <= is_mul ? mcnt_r + 3'd1 : 3'd0;
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X:   center_x_r   <= cfg_wdata;
          CFG_CENTER_Y:   center_y_r   <= cfg_wdata;
          CFG_AFFINE_C:   affine_c_r   <= cfg_wdata[17:0];
          CFG_AFFINE_D:   affine_d_r   <= cfg_wdata[17:0];
          CFG_AFFINE_E:   affine_e_r   <= cfg_wdata[17:0];
          CFG_POLY_TERMS: poly_terms_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.mode == MODE_LOAD &&
        6'(in_data.coef_index) < MAXT) begin
      coef_mem[AW'(in_data.coef_index)] <= in_data.coef_value;
    end
    coef_rd_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (mcnt_r)
      3'd0: begin
        ma_r  <= mag48(mul_a);
        mb_r  <= mag48(mul_b);
        neg_r <= mul_a[47] ^ mul_b[47];
        sh_r  <= mul_sh;
        acc_r <= 96'd0;
      end
      3'd6: mres_r <= neg_r ? 48'(-rnd_q) : 48'(rnd_q);
      default: ;
    endcase
    if (mcnt_r >= 3'd1 && mcnt_r <= 3'd4) prod_r <= pa * pb;
    case (mcnt_r)
      3'd2:    acc_r <= acc_r + 96'(prod_r);
      3'd3:    acc_r <= acc_r + (96'(prod_r) << 32);
      3'd4:    acc_r <= acc_r + (96'(prod_r) << 32);
      3'd5:    acc_r <= acc_r + (96'(prod_r) << 64);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r <= in_data.point_x;
        py_r <= in_data.point_y;
        pz_r <= in_data.point_z;
      end
      S_SQX: if (mul_done) rem_r <= acc_r[63:0];
      S_SQY: if (mul_done) begin
        rem_r <= rem_r + acc_r[63:0];
        res_r <= 64'd0;
        bit_r <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (rem_r >= sq_try) begin
          rem_r <= rem_r - sq_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_NINIT: begin
        n_r         <= res_r[31:0];
        at_center_r <= (res_r == 64'd0);
        m_r         <= (res_r[31:0] > zabs) ? 40'(res_r[31:0]) : 40'(zabs);
        cx_r        <= 44'(res_r[31:0]);
        cy_r        <= 44'(pz_r);
        th_r        <= 32'sd0;
      end
      S_NORM: if (!m_r[39]) begin
        m_r  <= m_r << 1;
        cx_r <= cx_r <<< 1;
        cy_r <= cy_r <<< 1;
      end
      S_CORD: begin
        if (!cy_r[43]) begin
          cx_r <= cx_r + (cy_r >>> cnt_r);
          cy_r <= cy_r - (cx_r >>> cnt_r);
          th_r <= th_r + $signed(atan_val(cnt_r));
        end else begin
          cx_r <= cx_r - (cy_r >>> cnt_r);
          cy_r <= cy_r + (cx_r >>> cnt_r);
          th_r <= th_r - $signed(atan_val(cnt_r));
        end
      end
      S_DXI, S_DYI: begin
        drem_r <= 33'(dnum[61:32]);
        dsh_r  <= dnum[31:0];
      end
      S_DIVX: begin
        drem_r <= drem_nxt;
        dsh_r  <= dq;
        if (cnt_r == 5'd31) qx_r <= px_r[31] ? -48'(dq) : 48'(dq);
      end
      S_DIVY: begin
        drem_r <= drem_nxt;
        dsh_r  <= dq;
        if (cnt_r == 5'd31) qy_r <= py_r[31] ? -48'(dq) : 48'(dq);
      end
      S_HINIT: k_r <= k_init;
      S_HSET:  rho_r <= coef_rd_r;
      S_HMUL: if (mul_done) begin
        rho_r <= sat48(49'(mres_r) + 49'(coef_rd_r));
        k_r   <= k_r - AW'(1);
      end
      S_XS: if (mul_done) xs_r <= mres_r;
      S_YS: if (mul_done) ys_r <= mres_r;
      S_U1: if (mul_done) ua_r <= 50'(mres_r);
      S_U2: if (mul_done) ua_r <= ua_r + 50'(mres_r);
      S_V1: if (mul_done) va_r <= 50'(mres_r);
      S_V2: if (mul_done) va_r <= va_r + 50'(mres_r);
      S_FIN: if (fin_go) begin
        out_data_r.at_center <= at_center_r;
        if (at_center_r) begin
          out_data_r.pixel_u <= {4'd0, center_x_r};
          out_data_r.pixel_v <= {4'd0, center_y_r};
        end else begin
          out_data_r.pixel_u <= sat32(51'(ua_r) + 51'(center_x_r));
          out_data_r.pixel_v <= sat32(51'(va_r) + 51'(center_y_r));
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_project: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == MODE_PROJECT) |=> !in_ready)
    else $error("projection request did not start the sequencer");

  a_cordic_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORD) |-> m_r[39])
    else $error("CORDIC started on an unnormalized vector");

  a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORD) |-> (cnt_r < 5'(CORDIC_STEPS)))
    else $error("CORDIC step count overran");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish state");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for fisheye_ray_to_pixel: drives coefficient loads and point
// projections with random handshake gaps and compares every pixel against a fixed-point
// predictor kept in this file. Depends on fr2p_pkg and the fisheye_ray_to_pixel RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fr2p_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_7 = 3'd7;
  localparam int NUM_SLOTS = MAX_TERMS_DEF;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fr2p_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fr2p_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  fisheye_ray_to_pixel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copies of the block's registers and coefficient table.
  logic [27:0] sh_center_x, sh_center_y;
  longint sh_aff_c, sh_aff_d, sh_aff_e;
  logic [4:0] sh_terms;
  longint coef_mirror [NUM_SLOTS];

  fr2p_out_t pending_pixels[$];
  int errors = 0;
  bit no_gaps = 1'b0;
  int out_stall = 0;

  function automatic logic [63:0] abs64(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Rounded a*b/2^sh, ties away from zero, clipped to 48 bits signed.
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [127:0] p;
    logic [63:0] lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 128'(abs64(a)) * 128'(abs64(b));
    p = (p + (128'd1 << (sh - 1))) >> sh;
    lim = (64'd1 << 47) - (neg ? 64'd0 : 64'd1);
    if (p > 128'(lim)) p = 128'(lim);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan_step(int i);
    longint steps [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149};
    return i < 10 ? steps[i] : (longint'(1) <<< (30 - i));
  endfunction

  function automatic longint cordic_angle(logic [63:0] n, longint z);
    logic [63:0] m;
    longint cx, cy, th, t;
    int s;
    m = n > abs64(z) ? n : abs64(z);
    s = 0;
    th = 0;
    while (m < (64'd1 << 39)) begin
      m <<= 1;
      s++;
    end
    cx = longint'(n << s);
    cy = z <<< s;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (cy >= 0) begin
        t = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        th += longint'(atan_step(i));
      end else begin
        t = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        th -= longint'(atan_step(i));
      end
      cx = t;
    end
    return th;
  endfunction

  function automatic longint planar_ratio(longint p, logic [63:0] n);
    logic [63:0] q;
    q = ((abs64(p) << 30) + (n >> 1)) / n;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic fr2p_out_t project_point(fr2p_in_t r);
    fr2p_out_t o;
    longint px, py, pz, th, rho, xs, ys, u, v;
    logic [63:0] n;
    int terms;
    px = longint'(r.point_x);
    py = longint'(r.point_y);
    pz = longint'(r.point_z);
    n = int_sqrt(abs64(px) * abs64(px) + abs64(py) * abs64(py));
    if (n == 0) begin
      o.pixel_u = 32'(sh_center_x);
      o.pixel_v = 32'(sh_center_y);
      o.at_center = 1'b1;
      return o;
    end
    th = cordic_angle(n, pz);
    terms = int'(sh_terms);
    if (terms < 1) terms = 1;
    if (terms > NUM_SLOTS) terms = NUM_SLOTS;
    rho = coef_mirror[terms - 1];
    for (int k = terms - 1; k > 0; k--)
      rho = clip(scaled_product(rho, th, 30) + coef_mirror[k - 1], 48);
    xs = scaled_product(planar_ratio(px, n), rho, 30);
    ys = scaled_product(planar_ratio(py, n), rho, 30);
    u = scaled_product(xs, sh_aff_c, 32) + scaled_product(ys, sh_aff_d, 32)
        + longint'(sh_center_x);
    v = scaled_product(xs, sh_aff_e, 32) + scaled_product(ys, 1, 16)
        + longint'(sh_center_y);
    o.pixel_u = 32'(clip(u, 32));
    o.pixel_v = 32'(clip(v, 32));
    o.at_center = 1'b0;
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls, with stretches of none when no_gaps is set.
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 99) < 20)
        out_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(15, 60);
    end
  end

  always @(posedge clk) begin
    fr2p_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result u=%0d v=%0d c=%0b",
                                   out_data.pixel_u, out_data.pixel_v, out_data.at_center);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_u !== want.pixel_u || out_data.pixel_v !== want.pixel_v ||
            out_data.at_center !== want.at_center) begin
          errors++;
          if (errors <= 10)
            $display("pixel differs: expected u=%0d v=%0d c=%0b, got u=%0d v=%0d c=%0b",
                     want.pixel_u, want.pixel_v, want.at_center,
                     out_data.pixel_u, out_data.pixel_v, out_data.at_center);
        end
      end
    end
  end

  task automatic send_item(fr2p_in_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    if (r.mode == MODE_LOAD) coef_mirror[r.coef_index] = longint'(r.coef_value);
    else pending_pixels = {pending_pixels, project_point(r)};
  endtask

  function automatic fr2p_in_t load_req(int idx, longint val);
    fr2p_in_t r;
    r.mode = MODE_LOAD;
    r.coef_index = 4'(idx);
    r.coef_value = 48'(val);
    r.point_x = $urandom;
    r.point_y = $urandom;
    r.point_z = $urandom;
    return r;
  endfunction

  function automatic fr2p_in_t point_req(int x, int y, int z);
    fr2p_in_t r;
    r.mode = MODE_PROJECT;
    r.coef_index = 4'($urandom);
    r.coef_value = 48'({$urandom, $urandom});
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      CFG_CENTER_X:   sh_center_x = d;
      CFG_CENTER_Y:   sh_center_y = d;
      CFG_AFFINE_C:   sh_aff_c = longint'(signed'(d[17:0]));
      CFG_AFFINE_D:   sh_aff_d = longint'(signed'(d[17:0]));
      CFG_AFFINE_E:   sh_aff_e = longint'(signed'(d[17:0]));
      CFG_POLY_TERMS: sh_terms = d[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Upper data bits above each register's width are filled with noise.
  task automatic set_config(logic [27:0] cx, logic [27:0] cy, logic [17:0] c,
                            logic [17:0] d, logic [17:0] e, logic [4:0] t);
    wait_idle();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_AFFINE_C, {10'($urandom), c});
    write_reg(CFG_AFFINE_D, {10'($urandom), d});
    write_reg(CFG_AFFINE_E, {10'($urandom), e});
    write_reg(CFG_POLY_TERMS, {23'($urandom), t});
    write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, 28'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint rand_coef();
    case ($urandom_range(0, 3))
      0: return longint'(signed'(48'({$urandom, $urandom})));
      1: return longint'($signed($urandom)) <<< 8;
      default: return longint'($signed($urandom)) <<< 2;
    endcase
  endfunction

  function automatic fr2p_in_t rand_point();
    int x, y, z;
    case ($urandom_range(0, 9))
      0: begin x = 0; y = 0; end
      1, 2: begin x = $urandom; y = $urandom; end
      3: begin x = $urandom_range(0, 1) ? 0 : $urandom; y = x == 0 ? $urandom : 0; end
      default: begin
        x = $signed($urandom) >>> $urandom_range(6, 14);
        y = $signed($urandom) >>> $urandom_range(6, 14);
      end
    endcase
    z = ($urandom_range(0, 3) == 0) ? $urandom : ($signed($urandom) >>> $urandom_range(4, 14));
    return point_req(x, y, z);
  endfunction

  task automatic test_reset_values();
    send_item(load_req(0, 64'sd200 <<< 32));
    send_item(point_req(32'sd65536, 32'sd65536, 32'sd65536));
    send_item(point_req(0, 0, 32'sh7FFF_FFFF));
  endtask

  task automatic test_field_extremes();
    set_config(28'h123_4567, 28'hFED_CBA9, 18'h10000, 18'h08000, 18'h3C000, 5'd4);
    send_item(load_req(1, -(64'sd50 <<< 32)));
    send_item(load_req(2, 64'sd3 <<< 30));
    send_item(load_req(3, 64'sh7FFF_FFFF_FFFF));
    send_item(point_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
    send_item(point_req(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(point_req(1, 0, 0));
    send_item(point_req(0, -1, 32'sh7FFF_FFFF));
    send_item(point_req(0, 0, 32'sh8000_0000));
    send_item(point_req(32'sh0001_0000, -32'sh0002_0000, 0));
  endtask

  task automatic test_term_count_clamp();
    for (int i = 4; i < NUM_SLOTS; i++) send_item(load_req(i, rand_coef() >>> 6));
    set_config(28'hFFF_FFFF, 28'hFFF_FFFF, 18'h1FFFF, 18'h20000, 18'h1FFFF, 5'd0);
    send_item(point_req(32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000));
    set_config(28'h0, 28'h0, 18'h20000, 18'h1FFFF, 18'h20000, 5'd31);
    send_item(point_req(-32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000));
    set_config(28'h200_0000, 28'h100_0000, 18'h10000, 18'h0, 18'h0, 5'd16);
    send_item(point_req(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_8000));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3)
        set_config(28'hFFF_FFFF, 28'h0, 18'h20000, 18'h20000, 18'h1FFFF, 5'd17);
      else
        set_config(28'($urandom), 28'($urandom), 18'($urandom), 18'($urandom),
                   18'($urandom), 5'($urandom_range(0, 31)));
      no_gaps = (ph == 5);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 4) == 0) send_item(load_req($urandom_range(0, 15), rand_coef()));
        else send_item(rand_point());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    sh_center_x = '0;
    sh_center_y = '0;
    sh_aff_c = 65536;
    sh_aff_d = 0;
    sh_aff_e = 0;
    sh_terms = 5'd1;
    foreach (coef_mirror[i]) coef_mirror[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_field_extremes();
    test_term_count_clamp();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += pending_pixels.size();
    if (errors == 0) begin
      $display("fisheye_ray_to_pixel: match");
    end else begin
      $display("fisheye_ray_to_pixel: mismatch");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("fisheye_ray_to_pixel: mismatch");
    $finish;
  end
endmodule

FILE: fisheye_ray_to_pixel.f
sv/fr2p_pkg.sv
sv/fisheye_ray_to_pixel.sv
dv/tb.sv
